FILE: rtl/sstdw_pkg.sv
// ----------------------------------------------------------------------------
// sstdw_pkg - shared types and constants of the seven-segment display writer
// Request kinds, bus constants, segment decode and inter-stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sstdw_pkg;

	// request kinds
	localparam logic [1:0] KIND_POWER = 2'd0;
	localparam logic [1:0] KIND_HEX   = 2'd1;
	localparam logic [1:0] KIND_TIME  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// bus constants
	localparam logic [7:0] CMD_BYTE        = 8'h48;
	localparam logic [7:0] POINT_BIT       = 8'h80;
	localparam logic [7:0] DIGIT_ADDR_BASE = 8'h68;

	localparam int DIGITS = 4;
	localparam int IDX_W  = 2;

	// time arithmetic
	localparam int SECS_W = 19;
	localparam int HR_W   = 7;
	localparam int MN_W   = 6;
	localparam int REM_W  = 12;
	localparam int TWO_W  = 7;   // two-digit value, 0..99

	localparam logic [SECS_W-1:0] SECS_MAX = 19'd359999;

	// floor(t/3600) = (t * 596524) >> 31, exact for t <= 359999
	localparam logic [19:0] RECIP_HR  = 20'd596524;
	localparam int          HR_SHIFT  = 31;
	// floor(r/60) = (r * 2185) >> 17, exact for r < 3600
	localparam logic [11:0] RECIP_MIN = 12'd2185;
	localparam int          MIN_SHIFT = 17;
	// floor(x/10) = (x * 205) >> 11, exact for x < 1029
	localparam logic [7:0]  RECIP_TEN = 8'd205;
	localparam int          TEN_SHIFT = 11;

	// fields common to every request, carried through the time stages
	typedef struct packed {
		logic [1:0]             kind;
		logic [DIGITS-1:0][3:0] digit;     // digit[0] is leftmost
		logic                   point;
		logic [3:0]             power;
		logic [3:0]             bright;
	} pass_t;

	// input of the formatter
	typedef struct packed {
		pass_t            pass;
		logic [TWO_W-1:0] hi;
		logic [TWO_W-1:0] lo;
	} fmt_in_t;

	// up to four words of one request
	typedef struct packed {
		logic                   cmd;       // single command word
		logic [IDX_W-1:0]       last_idx;
		logic [DIGITS-1:0][7:0] data;
	} burst_t;

	function automatic logic [7:0] seg_pattern(input logic [3:0] hex);
		logic [7:0] pat;
		case (hex)
			4'h0: pat = 8'h3f;
			4'h1: pat = 8'h06;
			4'h2: pat = 8'h5b;
			4'h3: pat = 8'h4f;
			4'h4: pat = 8'h66;
			4'h5: pat = 8'h6d;
			4'h6: pat = 8'h7d;
			4'h7: pat = 8'h07;
			4'h8: pat = 8'h7f;
			4'h9: pat = 8'h6f;
			4'ha: pat = 8'h77;
			4'hb: pat = 8'h7c;
			4'hc: pat = 8'h39;
			4'hd: pat = 8'h5e;
			4'he: pat = 8'h79;
			default: pat = 8'h71;
		endcase
		return pat;
	endfunction

	function automatic logic [7:0] digit_addr(input logic [IDX_W-1:0] idx);
		return DIGIT_ADDR_BASE + {5'b0, idx, 1'b0};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sstdw_if.sv
// ----------------------------------------------------------------------------
// sstdw_if - request and bus-write channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sstdw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  digit0;
	logic [3:0]  digit1;
	logic [3:0]  digit2;
	logic [3:0]  digit3;
	logic        point_on;
	logic [18:0] seconds;
	logic [3:0]  power_bits;
	logic [3:0]  brightness_level;

	modport source (
		output valid, req_type, digit0, digit1, digit2, digit3, point_on,
		       seconds, power_bits, brightness_level,
		input  ready
	);
	modport sink (
		input  valid, req_type, digit0, digit1, digit2, digit3, point_on,
		       seconds, power_bits, brightness_level,
		output ready
	);
endinterface

interface sstdw_wr_if;
	logic       valid;
	logic       ready;
	logic [7:0] target_byte;
	logic [7:0] payload_byte;
	logic       last_write;

	modport source (
		output valid, target_byte, payload_byte, last_write,
		input  ready
	);
	modport sink (
		input  valid, target_byte, payload_byte, last_write,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/sstdw_time_pipe.sv
// ----------------------------------------------------------------------------
// sstdw_time_pipe - request register and seconds-to-digits pipeline
// s1 registers the request, s2 hours, s3 minutes, s4 display pair.
// ----------------------------------------------------------------------------
`default_nettype none

module sstdw_time_pipe (
	input  logic               clk,
	input  logic               arst_n,
	sstdw_req_if.sink          req,
	output logic               out_valid,
	input  logic               out_ready,
	output sstdw_pkg::fmt_in_t out_data
);
	import sstdw_pkg::*;

	logic en1, en2, en3, en4;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	pass_t             pass_s1, pass_s2, pass_s3, pass_s4;
	logic [SECS_W-1:0] secs_s1;
	logic [SECS_W-1:0] t_s2;
	logic [HR_W-1:0]   hr_s2, hr_s3;
	logic [REM_W-1:0]  rem_s3;
	logic [MN_W-1:0]   mn_s3;
	logic [TWO_W-1:0]  hi_s4, lo_s4;

	logic [SECS_W-1:0] t_clamp;
	logic [38:0]       hr_prod;
	logic [SECS_W-1:0] hr_x3600;
	logic [SECS_W-1:0] rem_full;
	logic [23:0]       mn_prod;
	logic [REM_W-1:0]  mn_x60;
	logic [REM_W-1:0]  sc_full;
	logic              hour_mode;

	// a stage loads when it is empty or its word moves on
	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign req.ready = en1;

	// s2: clamp and hours
	assign t_clamp = (secs_s1 > SECS_MAX) ? SECS_MAX : secs_s1;
	assign hr_prod = 39'(t_clamp) * 39'(RECIP_HR);

	// s3: remainder within the hour, minutes
	assign hr_x3600 = (SECS_W'(hr_s2) << 12) - (SECS_W'(hr_s2) << 9)
	                + (SECS_W'(hr_s2) << 4);
	assign rem_full = t_s2 - hr_x3600;
	assign mn_prod  = 24'(rem_full[REM_W-1:0]) * 24'(RECIP_MIN);

	// s4: seconds, then mm:ss or hh:mm
	assign mn_x60    = (REM_W'(mn_s3) << 6) - (REM_W'(mn_s3) << 2);
	assign sc_full   = rem_s3 - mn_x60;
	assign hour_mode = (hr_s3 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			// the unused kind makes no words and is dropped here
			if (en1) valid_s1 <= req.valid && (req.req_type != KIND_NONE);
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pass_s1.kind     <= req.req_type;
			pass_s1.digit[0] <= req.digit0;
			pass_s1.digit[1] <= req.digit1;
			pass_s1.digit[2] <= req.digit2;
			pass_s1.digit[3] <= req.digit3;
			pass_s1.point    <= req.point_on;
			pass_s1.power    <= req.power_bits;
			pass_s1.bright   <= req.brightness_level;
			secs_s1          <= req.seconds;
		end
		if (en2) begin
			pass_s2 <= pass_s1;
			t_s2    <= t_clamp;
			hr_s2   <= hr_prod[HR_SHIFT +: HR_W];
		end
		if (en3) begin
			pass_s3 <= pass_s2;
			hr_s3   <= hr_s2;
			rem_s3  <= rem_full[REM_W-1:0];
			mn_s3   <= mn_prod[MIN_SHIFT +: MN_W];
		end
		if (en4) begin
			pass_s4 <= pass_s3;
			hi_s4   <= hour_mode ? hr_s3 : TWO_W'(mn_s3);
			lo_s4   <= hour_mode ? TWO_W'(mn_s3) : TWO_W'(sc_full[MN_W-1:0]);
		end
	end

	assign out_valid     = valid_s4;
	assign out_data.pass = pass_s4;
	assign out_data.hi   = hi_s4;
	assign out_data.lo   = lo_s4;

endmodule

`default_nettype wire

FILE: rtl/sstdw_burst_fmt.sv
// ----------------------------------------------------------------------------
// sstdw_burst_fmt - builds the words of one request
// Decimal split of the time pair, segment decode, command data.
// ----------------------------------------------------------------------------
`default_nettype none

module sstdw_burst_fmt (
	input  sstdw_pkg::fmt_in_t fmt_in,
	output sstdw_pkg::burst_t  burst
);
	import sstdw_pkg::*;

	function automatic logic [3:0] tens_of(input logic [TWO_W-1:0] x);
		logic [14:0] p;
		p = 15'(x) * 15'(RECIP_TEN);
		return p[TEN_SHIFT +: 4];
	endfunction

	function automatic logic [3:0] units_of(input logic [TWO_W-1:0] x);
		logic [3:0]       t;
		logic [TWO_W-1:0] u;
		t = tens_of(x);
		u = x - ((TWO_W'(t) << 3) + (TWO_W'(t) << 1));
		return u[3:0];
	endfunction

	logic [DIGITS-1:0][3:0] time_digit;

	assign time_digit[0] = tens_of(fmt_in.hi);
	assign time_digit[1] = units_of(fmt_in.hi);
	assign time_digit[2] = tens_of(fmt_in.lo);
	assign time_digit[3] = units_of(fmt_in.lo);

	always_comb begin
		burst = '0;
		unique case (fmt_in.pass.kind)
			KIND_POWER: begin
				burst.cmd      = 1'b1;
				burst.last_idx = '0;
				burst.data[0]  = {fmt_in.pass.bright, fmt_in.pass.power};
			end
			KIND_HEX: begin
				burst.last_idx = IDX_W'(DIGITS - 1);
				for (int k = 0; k < DIGITS; k++) begin
					burst.data[k] = seg_pattern(fmt_in.pass.digit[k])
					              | (fmt_in.pass.point ? POINT_BIT : 8'h00);
				end
			end
			KIND_TIME: begin
				burst.last_idx = IDX_W'(DIGITS - 1);
				for (int k = 0; k < DIGITS; k++) begin
					burst.data[k] = seg_pattern(time_digit[k]) | POINT_BIT;
				end
			end
			default: begin
				burst = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/sstdw_write_seq.sv
// ----------------------------------------------------------------------------
// sstdw_write_seq - output register and word sequencer
// Holds one request's words and hands them out one per cycle while wr.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sstdw_write_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sstdw_pkg::burst_t in_burst,
	sstdw_wr_if.source        wr
);
	import sstdw_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	burst_t           burst_q;
	logic             take;
	logic             at_last;

	assign at_last  = (idx_q == burst_q.last_idx);
	assign take     = busy_q && wr.ready;
	// next burst loads as the last word leaves
	assign in_ready = !busy_q || (wr.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) burst_q <= in_burst;
	end

	assign wr.valid        = busy_q;
	assign wr.target_byte  = burst_q.cmd ? CMD_BYTE : digit_addr(idx_q);
	assign wr.payload_byte = burst_q.data[idx_q];
	assign wr.last_write   = at_last;

endmodule

`default_nettype wire

FILE: rtl/seven_segment_time_display_writer.sv
// The first bus word is offered from the output register once the request has
// passed s1 to s4, and it leaves when wr.ready is high.
// Throughput: one word per cycle while wr.ready is high, from the single output
// word register; a command request is one word, a hex or time request four.
// A new request is taken while the previous one's words are still leaving.
// Reset (arst_n, asynchronous, active low) empties every stage and the
// output register; no words are pending after reset.
// ----------------------------------------------------------------------------
// seven_segment_time_display_writer - display request to bus word converter
// Turns power/brightness, hex-digit and time requests into the two-byte
// writes of a four-digit seven-segment driver.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_time_display_writer (
	input  logic       clk,
	input  logic       arst_n,
	sstdw_req_if.sink  req,
	sstdw_wr_if.source wr
);
	import sstdw_pkg::*;

	// s4 result of the time pipeline, and the formatted words
	logic    fmt_valid;
	logic    fmt_ready;
	fmt_in_t fmt_in;
	burst_t  burst;

	// s1..s4: request register, hours, minutes, display pair.
	// Hex and command requests ride along unchanged.
	sstdw_time_pipe u_time_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (fmt_valid),
		.out_ready (fmt_ready),
		.out_data  (fmt_in)
	);

	// decimal split, segment decode and command data, between s4 and the
	// output register
	sstdw_burst_fmt u_burst_fmt (
		.fmt_in (fmt_in),
		.burst  (burst)
	);

	// output register: one word per cycle while wr.ready is high, last word flagged
	sstdw_write_seq u_write_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fmt_valid),
		.in_ready (fmt_ready),
		.in_burst (burst),
		.wr       (wr)
	);

endmodule

`default_nettype wire

FILE: rtl/sstdw_checker.sv
// ----------------------------------------------------------------------------
// sstdw_checker - port-level checks of the display writer
// Burst ordering of the bus words and output hold under back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module sstdw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       wr_valid,
	input logic       wr_ready,
	input logic [7:0] target_byte,
	input logic [7:0] payload_byte,
	input logic       last_write
);
	import sstdw_pkg::*;

	// a word held back must not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_ready |=> wr_valid && $stable(target_byte)
			&& $stable(payload_byte) && $stable(last_write))
		else $error("output word changed while stalled");

	// a burst continues without a gap until its last word
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && !last_write |=> wr_valid)
		else $error("gap inside a digit burst");

	// digit addresses step by two within a burst
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && !last_write |=> target_byte == $past(target_byte) + 8'd2)
		else $error("digit address out of order");

	// a command is a single word; a digit burst ends on the rightmost digit
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && (target_byte == CMD_BYTE || last_write) |->
			last_write && (target_byte == CMD_BYTE || target_byte == digit_addr(2'd3)))
		else $error("burst ends on the wrong word");

endmodule

bind seven_segment_time_display_writer sstdw_checker u_sstdw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.wr_valid     (wr.valid),
	.wr_ready     (wr.ready),
	.target_byte  (wr.target_byte),
	.payload_byte (wr.payload_byte),
	.last_write   (wr.last_write)
);

`default_nettype wire
